/* rtl/core/hmpf_pkg.sv */
// Package for the half-maximum peak finder: sizes, controller states,
// and the command and status groups passed between controller and datapath.
// No dependencies.
`default_nettype none

package hmpf_pkg;

    // Profile store and sample sizing.
    localparam int PROFILE_DEPTH = 128;
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_RESULTS   = 63;

    // Derived widths.
    localparam int IDX_W   = $clog2(PROFILE_DEPTH);
    localparam int CNT_W   = $clog2(PROFILE_DEPTH + 1);
    localparam int COUNT_W = $clog2(MAX_RESULTS + 1);
    localparam int RES_W   = 7;

    // Controller states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SWEEP,
        ST_WL_RD,
        ST_WL_CHK,
        ST_WR_RD,
        ST_WR_CHK,
        ST_PUSH,
        ST_END
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_init;
        logic sweep;
        logic hold_peak;
        logic rd_left;
        logic step_left;
        logic rd_right;
        logic step_right;
        logic resume;
        logic push_peak;
        logic push_final;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_prof;
        logic win_peak;
        logic sweep_end;
        logic left_go;
        logic right_go;
        logic pend_vld;
        logic out_free;
        logic count_full;
    } t_sts;

    // Fit a store index into a result field, masking or zero-extending.
    function automatic logic [RES_W-1:0] to_res(input logic [IDX_W-1:0] idx);
        logic [IDX_W+RES_W-1:0] wide;
        wide = {{RES_W{1'b0}}, idx};
        return wide[RES_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hmpf_if.sv */
// Valid/ready channel interfaces for the sample input and the peak results.
// Depends on hmpf_pkg for the field widths.
`default_nettype none

interface hmpf_in_if;
    logic                             valid;
    logic                             ready;
    logic [hmpf_pkg::SAMPLE_BITS-1:0] sample;
    logic                             last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface hmpf_out_if;
    logic                       valid;
    logic                       ready;
    logic [hmpf_pkg::RES_W-1:0] peak_index;
    logic [hmpf_pkg::RES_W-1:0] peak_width;
    logic                       peak_found;
    logic                       final_result;
    logic                       truncated;

    modport source (output valid, output peak_index, output peak_width,
                    output peak_found, output final_result, output truncated,
                    input ready);
    modport sink (input valid, input peak_index, input peak_width,
                  input peak_found, input final_result, input truncated,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/hmpf_ctrl.sv */
// Controller state machine of the peak finder: load, sweep, half-maximum walks
// and result hand-off. Depends on hmpf_pkg for states, commands and status.
`default_nettype none

module hmpf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_last,
    input  wire hmpf_pkg::t_sts i_sts,
    output hmpf_pkg::t_cmd      o_cmd,
    output logic                o_in_ready
);

    hmpf_pkg::t_state r_state;
    hmpf_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmpf_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == hmpf_pkg::ST_LOAD);
        case (r_state)
            hmpf_pkg::ST_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = hmpf_pkg::ST_SCAN;
                    end
                end
            end
            hmpf_pkg::ST_SCAN: begin
                if (i_sts.short_prof) begin
                    n_state = hmpf_pkg::ST_END;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = hmpf_pkg::ST_SWEEP;
                end
            end
            hmpf_pkg::ST_SWEEP: begin
                // A peak in the window takes priority over the end of the sweep.
                if (i_sts.win_peak) begin
                    o_cmd.hold_peak = 1'b1;
                    n_state         = hmpf_pkg::ST_WL_RD;
                end else if (i_sts.sweep_end) begin
                    n_state = hmpf_pkg::ST_END;
                end else begin
                    o_cmd.sweep = 1'b1;
                end
            end
            hmpf_pkg::ST_WL_RD: begin
                o_cmd.rd_left = 1'b1;
                n_state       = hmpf_pkg::ST_WL_CHK;
            end
            hmpf_pkg::ST_WL_CHK: begin
                if (i_sts.left_go) begin
                    o_cmd.step_left = 1'b1;
                    n_state         = hmpf_pkg::ST_WL_RD;
                end else begin
                    n_state = hmpf_pkg::ST_WR_RD;
                end
            end
            hmpf_pkg::ST_WR_RD: begin
                o_cmd.rd_right = 1'b1;
                n_state        = hmpf_pkg::ST_WR_CHK;
            end
            hmpf_pkg::ST_WR_CHK: begin
                if (i_sts.right_go) begin
                    o_cmd.step_right = 1'b1;
                    n_state          = hmpf_pkg::ST_WR_RD;
                end else begin
                    n_state = hmpf_pkg::ST_PUSH;
                end
            end
            hmpf_pkg::ST_PUSH: begin
                // The previous peak moves to the output only when it is free.
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    o_cmd.push_peak = 1'b1;
                    if (i_sts.count_full) begin
                        n_state = hmpf_pkg::ST_END;
                    end else begin
                        o_cmd.resume = 1'b1;
                        n_state      = hmpf_pkg::ST_SWEEP;
                    end
                end
            end
            hmpf_pkg::ST_END: begin
                if (i_sts.out_free) begin
                    o_cmd.push_final = 1'b1;
                    n_state          = hmpf_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = hmpf_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/hmpf_datapath.sv */
// Datapath of the peak finder: sample store, three-sample sweep window,
// half-maximum bounds, pending result and output register. Depends on hmpf_pkg.
`default_nettype none

module hmpf_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire hmpf_pkg::t_cmd                   i_cmd,
    output hmpf_pkg::t_sts                        o_sts,
    input  wire logic [hmpf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [hmpf_pkg::RES_W-1:0]            o_peak_index,
    output logic [hmpf_pkg::RES_W-1:0]            o_peak_width,
    output logic                                  o_peak_found,
    output logic                                  o_final_result,
    output logic                                  o_truncated
);

    localparam int SB = hmpf_pkg::SAMPLE_BITS;
    localparam int IW = hmpf_pkg::IDX_W;
    localparam int CW = hmpf_pkg::CNT_W;
    localparam int KW = hmpf_pkg::COUNT_W;
    localparam int RW = hmpf_pkg::RES_W;

    // Sample store.
    logic [SB-1:0] mem [hmpf_pkg::PROFILE_DEPTH];
    logic [SB-1:0] r_rd_data;

    // Load bookkeeping.
    logic [CW-1:0] r_fill;
    logic          r_ovf;

    // Sweep window: samples at center-1, center, center+1.
    logic [SB-1:0] r_win0;
    logic [SB-1:0] r_win1;
    logic [SB-1:0] r_win2;
    logic [1:0]    r_win_cnt;
    logic          r_win_new;
    logic [IW-1:0] r_center;
    logic [CW-1:0] r_addr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    // Half-maximum walk.
    logic [IW-1:0] r_left;
    logic [IW-1:0] r_right;
    logic [SB-1:0] r_pk;

    // Pending peak result and count.
    logic          r_pend_vld;
    logic [RW-1:0] r_pend_index;
    logic [RW-1:0] r_pend_width;
    logic [KW-1:0] r_count;

    // Output register.
    logic          r_out_vld;
    logic [RW-1:0] r_out_index;
    logic [RW-1:0] r_out_width;
    logic          r_out_found;
    logic          r_out_final;
    logic          r_out_trunc;

    logic          fill_full;
    logic          addr_ok;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          out_free;
    logic [SB:0]   dbl_rd;
    logic          half_above;
    logic          push_any;

    // Read address selection and helper compares.
    always_comb begin
        fill_full  = (r_fill == CW'(hmpf_pkg::PROFILE_DEPTH));
        addr_ok    = (r_addr < r_fill);
        rd_en      = (i_cmd.sweep && addr_ok) || i_cmd.rd_left || i_cmd.rd_right;
        rd_addr    = r_addr[IW-1:0];
        if (i_cmd.rd_left) begin
            rd_addr = r_left;
        end else if (i_cmd.rd_right) begin
            rd_addr = r_right;
        end
        out_free   = !r_out_vld || i_out_ready;
        dbl_rd     = {r_rd_data, 1'b0};
        half_above = (dbl_rd > {1'b0, r_pk});
        push_any   = (i_cmd.push_peak && r_pend_vld) || i_cmd.push_final;
    end

    // Status to the controller.
    always_comb begin
        o_sts.short_prof = (r_fill < CW'(3));
        o_sts.win_peak   = r_win_new && (r_win_cnt == 2'd3) &&
                           (r_win1 > r_win0) && (r_win1 > r_win2);
        o_sts.sweep_end  = (r_win_cnt == 2'd3) &&
                           ((CW'(r_center) + CW'(2)) == r_fill);
        o_sts.left_go    = (r_left != '0) && half_above;
        o_sts.right_go   = ((CW'(r_right) + CW'(1)) < r_fill) && half_above;
        o_sts.pend_vld   = r_pend_vld;
        o_sts.out_free   = out_free;
        o_sts.count_full = (r_count == KW'(hmpf_pkg::MAX_RESULTS - 1));
    end

    // Store write during loading and a single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !fill_full) begin
            mem[r_fill[IW-1:0]] <= i_sample;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_ovf      <= 1'b0;
            r_win_cnt  <= '0;
            r_win_new  <= 1'b0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_left     <= '0;
            r_right    <= '0;
            r_pend_vld <= 1'b0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            // Loading: keep what fits, flag the rest.
            if (i_cmd.load) begin
                if (fill_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end

            // Sweep start, sample stream and restart after a walk.
            r_rd_vld <= i_cmd.sweep && addr_ok;
            if (i_cmd.scan_init) begin
                r_win_cnt  <= '0;
                r_win_new  <= 1'b0;
                r_addr     <= '0;
                r_pend_vld <= 1'b0;
                r_count    <= '0;
            end
            if (i_cmd.sweep) begin
                if (r_rd_vld) begin
                    r_win_new <= 1'b1;
                    if (r_win_cnt != 2'd3) begin
                        r_win_cnt <= r_win_cnt + 2'd1;
                    end
                end
                if (addr_ok) begin
                    r_addr <= r_addr + CW'(1);
                end
            end
            if (i_cmd.resume) begin
                r_addr <= CW'(r_center) + CW'(2);
            end

            // Half-maximum bounds.
            if (i_cmd.hold_peak) begin
                r_win_new <= 1'b0;
                r_left    <= r_center;
                r_right   <= r_center;
            end
            if (i_cmd.step_left) begin
                r_left <= r_left - IW'(1);
            end
            if (i_cmd.step_right) begin
                r_right <= r_right + IW'(1);
            end

            // Result bookkeeping.
            if (i_cmd.push_peak) begin
                r_pend_vld <= 1'b1;
                r_count    <= r_count + KW'(1);
            end
            if (i_cmd.push_final) begin
                r_pend_vld <= 1'b0;
                r_fill     <= '0;
                r_ovf      <= 1'b0;
            end

            // Output valid holds until the transaction completes.
            if (push_any) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            if (r_rd_vld) begin
                r_win0   <= r_win1;
                r_win1   <= r_win2;
                r_win2   <= r_rd_data;
                r_center <= r_rd_idx - IW'(1);
            end
            r_rd_idx <= r_addr[IW-1:0];
        end
        if (i_cmd.hold_peak) begin
            r_pk <= r_win1;
        end
        if (i_cmd.push_peak) begin
            r_pend_index <= hmpf_pkg::to_res(r_center);
            r_pend_width <= hmpf_pkg::to_res(r_right - r_left);
        end
        if (i_cmd.push_peak && r_pend_vld) begin
            r_out_index <= r_pend_index;
            r_out_width <= r_pend_width;
            r_out_found <= 1'b1;
            r_out_final <= 1'b0;
            r_out_trunc <= r_ovf;
        end
        if (i_cmd.push_final) begin
            // Last peak of the profile, or the marker when none was found.
            r_out_index <= r_pend_vld ? r_pend_index : '0;
            r_out_width <= r_pend_vld ? r_pend_width : '0;
            r_out_found <= r_pend_vld;
            r_out_final <= 1'b1;
            r_out_trunc <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_peak_index   = r_out_index;
    assign o_peak_width   = r_out_width;
    assign o_peak_found   = r_out_found;
    assign o_final_result = r_out_final;
    assign o_truncated    = r_out_trunc;

`ifndef SYNTHESIS
    // A result never overwrites one that is still waiting at the output.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_any |-> out_free)
        else $error("result pushed while the output register was occupied");

    // The left bound never passes the right bound.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_right)
        else $error("half-maximum bounds crossed");

    // The fill count stays within the store.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(hmpf_pkg::PROFILE_DEPTH))
        else $error("fill count beyond the store depth");

    // No more peaks than the result limit are collected.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_peak |=> r_count <= KW'(hmpf_pkg::MAX_RESULTS))
        else $error("peak count beyond the result limit");
`endif

endmodule

`default_nettype wire

/* rtl/core/half_max_peak_finder.sv */
// Half-maximum peak finder. Loading takes one sample per cycle; the scan starts
// in the cycle after the last sample and holds off input until the final result
// enters the output register. A scan streams the samples through the single
// store read port; for each peak it walks left, then right, reading and then
// checking one sample per step, then hands the result off and refills the window.
// Synchronous active-low reset returns to loading with an empty store.
`default_nettype none

module half_max_peak_finder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hmpf_in_if.sink   i_in,
    hmpf_out_if.source o_out
);

    hmpf_pkg::t_cmd cmd;
    hmpf_pkg::t_sts sts;
    logic           in_ready;

    // Controller.
    hmpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_sample),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    assign i_in.ready = in_ready;

    // Datapath.
    hmpf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_sample       (i_in.sample),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_peak_index   (o_out.peak_index),
        .o_peak_width   (o_out.peak_width),
        .o_peak_found   (o_out.peak_found),
        .o_final_result (o_out.final_result),
        .o_truncated    (o_out.truncated)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for half_max_peak_finder: streams sample profiles through
// the input channel and checks every peak result against the directed table or a behavioral predictor.
// Depends on hmpf_pkg, hmpf_in_if, hmpf_out_if and the half_max_peak_finder RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB           = hmpf_pkg::SAMPLE_BITS;
    localparam int RW           = hmpf_pkg::RES_W;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 320;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int BIG_PROFILE  = hmpf_pkg::PROFILE_DEPTH + 2;
    localparam int BIG_SLOT     = 6;

    // Profile shapes used by the random part.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_HALF_EDGE,
        SHAPE_RAMP,
        SHAPE_TINY,
        SHAPE_LOW
    } t_shape;

    // One peak result, in the order of the output fields.
    typedef struct packed {
        logic [RW-1:0] pk_index;
        logic [RW-1:0] pk_width;
        logic          found;
        logic          is_final;
        logic          trunc;
    } t_peak_rec;

    // One row of the directed stimulus table.
    typedef struct {
        logic [SB-1:0] smp;
        logic          lst;
        bit            typed;
        t_peak_rec     want;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    hmpf_in_if  sample_ch ();
    hmpf_out_if peak_ch ();

    half_max_peak_finder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_ch),
        .o_out   (peak_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: the profile being collected and its overflow flag.
    logic [SB-1:0] profile_mem [hmpf_pkg::PROFILE_DEPTH];
    int unsigned   fill_len = 0;
    logic          over_flag = 1'b0;

    t_peak_rec     scan_out [$];
    t_peak_rec     peaks_due [$];
    t_stim_row     stim_rows [$];
    logic [SB-1:0] next_profile [$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_active = 1'b0;

    int err_count = 0;
    int samples_taken = 0;
    int profiles_done = 0;
    int trunc_profiles = 0;
    int peaks_checked = 0;
    int markers_checked = 0;

    t_peak_rec mon_got;
    t_peak_rec mon_want;

    // Predicts the results of one sample transaction into scan_out.
    function automatic void predict_sample(input logic [SB-1:0] smp, input logic lst);
        int unsigned pos;
        int unsigned lo;
        int unsigned hi;
        int unsigned pk;
        int unsigned span;
        int unsigned hits;
        t_peak_rec   rec;
        scan_out.delete();
        if (fill_len < hmpf_pkg::PROFILE_DEPTH) begin
            profile_mem[fill_len] = smp;
            fill_len++;
        end else begin
            over_flag = 1'b1;
        end
        if (!lst) return;

        // Strict interior maxima, each walked out to its half-maximum bounds.
        hits = 0;
        for (pos = 1; pos + 1 < fill_len && hits < hmpf_pkg::MAX_RESULTS; pos++) begin
            pk = profile_mem[pos];
            if (pk > profile_mem[pos - 1] && pk > profile_mem[pos + 1]) begin
                lo = pos;
                hi = pos;
                while (lo > 0 && 2 * profile_mem[lo] > pk) lo--;
                while (hi + 1 < fill_len && 2 * profile_mem[hi] > pk) hi++;
                span = hi - lo;
                rec.pk_index = pos[RW-1:0];
                rec.pk_width = span[RW-1:0];
                rec.found    = 1'b1;
                rec.is_final = 1'b0;
                rec.trunc    = over_flag;
                scan_out = {scan_out, rec};
                hits++;
            end
        end

        // An empty scan still yields one marker; otherwise flag the last peak.
        if (hits == 0) begin
            rec = '0;
            rec.is_final = 1'b1;
            rec.trunc    = over_flag;
            scan_out = {scan_out, rec};
        end else begin
            scan_out[scan_out.size() - 1].is_final = 1'b1;
        end
        profiles_done++;
        if (over_flag) trunc_profiles++;
        fill_len  = 0;
        over_flag = 1'b0;
    endfunction

    function automatic void add_row(input logic [SB-1:0] smp, input logic lst,
                                    input bit typed, input int idx, input int wid,
                                    input logic found);
        t_stim_row row;
        row.smp            = smp;
        row.lst            = lst;
        row.typed          = typed;
        row.want.pk_index  = idx[RW-1:0];
        row.want.pk_width  = wid[RW-1:0];
        row.want.found     = found;
        row.want.is_final  = 1'b1;
        row.want.trunc     = 1'b0;
        stim_rows = {stim_rows, row};
    endfunction

    // Offers one sample transaction and books its expected results once accepted.
    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_sample(input logic [SB-1:0] smp, input logic lst,
                               input bit typed, input t_peak_rec want);
        t_peak_rec rec;
        while ($urandom_range(99) < idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= smp;
        sample_ch.last_sample <= lst;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        samples_taken++;
        predict_sample(smp, lst);
        if (typed) begin
            peaks_due = {peaks_due, want};
        end else begin
            while (scan_out.size() > 0) begin
                rec = scan_out.pop_front();
                peaks_due = {peaks_due, rec};
            end
        end
        @(negedge clk);
    endtask

    // Builds one random profile of the given shape into next_profile.
    task automatic build_profile(input t_shape shape);
        int len;
        int k;
        int v;
        int pk;
        next_profile.delete();
        case (shape)
            SHAPE_NOISE: begin
                len = $urandom_range(3, 20);
                for (k = 0; k < len; k++)
                    next_profile = {next_profile, SB'($urandom_range(0, 65535))};
            end
            SHAPE_HALF_EDGE: begin
                // Peaks flanked by samples at half the peak rounded down, or one above it.
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    pk = $urandom_range(2, 65535);
                    next_profile = {next_profile, SB'($urandom_range(0, 100))};
                    next_profile = {next_profile, SB'(pk / 2 + $urandom_range(0, 1))};
                    next_profile = {next_profile, SB'(pk)};
                    next_profile = {next_profile, SB'(pk / 2 + $urandom_range(0, 1))};
                    if ($urandom_range(1)) next_profile = {next_profile, SB'(pk / 2 + 1)};
                end
                if ($urandom_range(1))
                    next_profile = {next_profile, SB'($urandom_range(0, 65535))};
            end
            SHAPE_RAMP: begin
                // Slow random walk gives wide peaks and long edge walks.
                len = $urandom_range(20, 48);
                v = $urandom_range(0, 65535);
                for (k = 0; k < len; k++) begin
                    v = v + $urandom_range(0, 8000) - 4000;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    next_profile = {next_profile, SB'(v)};
                end
            end
            SHAPE_TINY: begin
                len = $urandom_range(1, 3);
                v = $urandom_range(0, 65535);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(1)) next_profile = {next_profile, SB'(v)};
                    else next_profile = {next_profile, SB'($urandom_range(0, 65535))};
                end
            end
            default: begin
                // Tiny values: many plateaus and near-ties.
                len = $urandom_range(3, 16);
                for (k = 0; k < len; k++)
                    next_profile = {next_profile, SB'($urandom_range(0, 3))};
            end
        endcase
    endtask

    task automatic report_field(input string field, input int want_v, input int got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        err_count++;
    endtask

    // Receiver: random stalls, overridden by the long hold.
    initial peak_ch.ready = 1'b0;
    always @(negedge clk) begin
        if (hold_active) begin
            peak_ch.ready <= 1'b0;
        end else begin
            peak_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Long receiver hold, counted here while the sender keeps offering.
    initial begin : receiver_hold
        @(posedge hold_request);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && peak_ch.valid === 1'b1 && peak_ch.ready === 1'b1) begin
            mon_got = {peak_ch.peak_index, peak_ch.peak_width, peak_ch.peak_found,
                       peak_ch.final_result, peak_ch.truncated};
            if (peaks_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d width %0d",
                         $time, mon_got.pk_index, mon_got.pk_width);
                err_count++;
            end else begin
                mon_want = peaks_due.pop_front();
                if (mon_got.pk_index !== mon_want.pk_index)
                    report_field("peak_index", mon_want.pk_index, mon_got.pk_index);
                if (mon_got.pk_width !== mon_want.pk_width)
                    report_field("peak_width", mon_want.pk_width, mon_got.pk_width);
                if (mon_got.found !== mon_want.found)
                    report_field("peak_found", mon_want.found, mon_got.found);
                if (mon_got.is_final !== mon_want.is_final)
                    report_field("final_result", mon_want.is_final, mon_got.is_final);
                if (mon_got.trunc !== mon_want.trunc)
                    report_field("truncated", mon_want.trunc, mon_got.trunc);
                if (mon_want.found) peaks_checked++;
                else markers_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still expected",
                 CYCLE_LIMIT, peaks_due.size());
        $display("testbench: errors");
        $finish;
    end

    // Stimulus: directed table, then random profiles under changing idle patterns.
    initial begin : stimulus
        int        i;
        int        k;
        int        profile_no;
        int        random_items;
        int        mode;
        t_shape    shape;
        t_peak_rec none;
        none = '0;
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.sample      = '0;
        sample_ch.last_sample = 1'b0;

        // Single sample and two samples: no interior index, so only a marker.
        add_row(16'hFFFF, 1'b1, 1'b1, 0, 0, 1'b0);
        add_row(16'h0000, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'hFFFF, 1'b1, 1'b1, 0, 0, 1'b0);
        // Full-scale peak between zeros: the walk reaches both profile ends.
        add_row(16'h0000, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'hFFFF, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'h0000, 1'b1, 1'b1, 1, 2, 1'b1);
        // A plateau is not a strict maximum.
        add_row(16'd7, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd7, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd7, 1'b1, 1'b1, 0, 0, 1'b0);
        // Two peaks in one profile.
        add_row(16'd1, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd5, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd2, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd9, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd0, 1'b1, 1'b0, 0, 0, 1'b0);
        // Neighbors exactly at half the peak stop the walk.
        add_row(16'd0, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd10, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd20, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd10, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd0, 1'b1, 1'b0, 0, 0, 1'b0);
        // Neighbors just above half let the walk pass.
        add_row(16'd0, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd11, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd20, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd11, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(16'd0, 1'b1, 1'b0, 0, 0, 1'b0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < stim_rows.size(); i++)
            send_sample(stim_rows[i].smp, stim_rows[i].lst, stim_rows[i].typed,
                        stim_rows[i].want);

        profile_no   = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            // Idle pattern changes every few profiles.
            mode = (profile_no / 3) % 4;
            idle_pct  = (mode == 1) ? 65 : ((mode == 3) ? 37 : 0);
            stall_pct = (mode == 2) ? 65 : ((mode == 3) ? 37 : 0);

            if (profile_no == BIG_SLOT) begin
                // Alternating profile past the store depth: most peaks, truncated,
                // with the receiver held off so the scan backs up into the input.
                next_profile.delete();
                for (k = 0; k < BIG_PROFILE; k++) begin
                    if (k % 2) next_profile = {next_profile, SB'($urandom_range(32768, 65535))};
                    else next_profile = {next_profile, SB'($urandom_range(0, 32767))};
                end
                hold_request = 1'b1;
            end else begin
                k = $urandom_range(0, 9);
                if (k < 3) shape = SHAPE_NOISE;
                else if (k < 6) shape = SHAPE_HALF_EDGE;
                else if (k == 6) shape = SHAPE_RAMP;
                else if (k == 7) shape = SHAPE_TINY;
                else shape = SHAPE_LOW;
                build_profile(shape);
            end

            for (k = 0; k < next_profile.size(); k++)
                send_sample(next_profile[k], k == next_profile.size() - 1, 1'b0, none);
            random_items += next_profile.size();
            profile_no++;
        end
        sample_ch.valid <= 1'b0;

        // Let the last results drain, then watch for strays.
        idle_pct  = 0;
        stall_pct = 0;
        while (peaks_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d samples in %0d profiles (%0d truncated)",
                 samples_taken, profiles_done, trunc_profiles);
        $display("checked %0d peak results and %0d empty-profile markers",
                 peaks_checked, markers_checked);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
